FILE: design/dqdv_pkg.sv
// ----------------------------------------------------------------------------
// dqdv_pkg: shared definitions for the double-ended queue with delete by value
// Sizes, operation and status codes, and the command that drives the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package dqdv_pkg;

	// Queue sizing.
	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int IDX_W      = $clog2(DEPTH);

	typedef logic [DATA_WIDTH-1:0] word_t;
	typedef logic [CNT_W-1:0]      count_t;

	// Operation codes carried by a transaction.
	localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
	localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_DELETE     = 3'd4;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	// Commands broadcast to every cell of the row.
	localparam logic [2:0] CMD_HOLD        = 3'd0;
	localparam logic [2:0] CMD_LOAD_TAIL   = 3'd1;
	localparam logic [2:0] CMD_SHIFT_BACK  = 3'd2;
	localparam logic [2:0] CMD_SHIFT_FRONT = 3'd3;
	localparam logic [2:0] CMD_DELETE      = 3'd4;

	typedef struct packed {
		logic [2:0] code;
		word_t      word;
	} cell_cmd_t;

endpackage

`default_nettype wire

FILE: design/deque_with_delete_by_value.sv
// ----------------------------------------------------------------------------
// deque_with_delete_by_value: bounded double-ended queue with delete by value
// A row of cells holds the entries in order; pushes, pops and the delete
// search with gap closing are all done by the whole row at once.
// ----------------------------------------------------------------------------
// The result strobe done rises in the cycle after start is taken.
// Throughput: one transaction per cycle; busy stays low, as the whole cell
// row updates in the cycle a transaction is taken.
// Reset: arst_n clears the entry count and the result strobe; entry contents
// are left as they are and are never read before being written.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module deque_with_delete_by_value (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  operation,
	input  wire logic [31:0] value,
	output logic             done,
	output logic [31:0]      popped_value,
	output logic [1:0]       status,
	output logic [4:0]       entry_count,
	output logic [31:0]      front_value,
	output logic [31:0]      back_value
);
	import dqdv_pkg::*;

	cell_cmd_t        cmd;
	word_t            cell_data [DEPTH];
	logic [DEPTH:0]   found;
	logic [DEPTH-1:0] occupied;
	logic [DEPTH-1:0] at_tail;
	logic             full;
	logic             empty;
	logic [IDX_W-1:0] back_idx;
	count_t           count_q;
	count_t           count_d;
	logic             done_q;
	word_t            popped_q;
	word_t            popped_d;
	logic [1:0]       status_q;
	logic [1:0]       status_d;

	assign busy     = 1'b0;
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign back_idx = IDX_W'(count_q - CNT_W'(1));
	assign found[0] = 1'b0;

	// Cell row with occupancy flags derived from the entry count.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign occupied[i] = (CNT_W'(i) < count_q);
		assign at_tail[i]  = (CNT_W'(i) == count_q);

		dqdv_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.occupied   (occupied[i]),
			.at_tail    (at_tail[i]),
			.left_data  ((i == 0) ? cmd.word : cell_data[(i == 0) ? 0 : i - 1]),
			.right_data (cell_data[(i == DEPTH - 1) ? i : i + 1]),
			.found_in   (found[i]),
			.found_out  (found[i+1]),
			.data       (cell_data[i])
		);
	end

	// Decode the transaction into a row command and the next result.
	always_comb begin
		cmd.code = CMD_HOLD;
		cmd.word = DATA_WIDTH'(value);
		count_d  = count_q;
		popped_d = '0;
		status_d = ST_OK;
		if (start) begin
			case (operation)
				OP_PUSH_BACK: begin
					if (full) begin
						status_d = ST_FULL;
					end else begin
						cmd.code = CMD_LOAD_TAIL;
						count_d  = count_q + CNT_W'(1);
					end
				end
				OP_PUSH_FRONT: begin
					if (full) begin
						status_d = ST_FULL;
					end else begin
						cmd.code = CMD_SHIFT_BACK;
						count_d  = count_q + CNT_W'(1);
					end
				end
				OP_POP_FRONT: begin
					if (empty) begin
						status_d = ST_EMPTY;
					end else begin
						cmd.code = CMD_SHIFT_FRONT;
						popped_d = cell_data[0];
						count_d  = count_q - CNT_W'(1);
					end
				end
				OP_POP_BACK: begin
					if (empty) begin
						status_d = ST_EMPTY;
					end else begin
						popped_d = cell_data[back_idx];
						count_d  = count_q - CNT_W'(1);
					end
				end
				OP_DELETE: begin
					cmd.code = CMD_DELETE;
					if (found[DEPTH]) begin
						count_d = count_q - CNT_W'(1);
					end else begin
						status_d = ST_NOTFOUND;
					end
				end
				default: begin
					status_d = ST_OK;
				end
			endcase
		end
	end

	// Control state: entry count and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= start;
		end
	end

	// Result payload registers.
	always_ff @(posedge clk) begin
		popped_q <= popped_d;
		status_q <= status_d;
	end

	// The cells already hold the state after the transaction, so front and
	// back are read straight from the row.
	assign done         = done_q;
	assign popped_value = 32'(popped_q);
	assign status       = status_q;
	assign entry_count  = 5'(count_q);
	assign front_value  = empty ? 32'd0 : 32'(cell_data[0]);
	assign back_value   = empty ? 32'd0 : 32'(cell_data[back_idx]);

	// The entry count never exceeds the depth of the row.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	// A full status is only reported with the row full.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (count_q == CNT_W'(DEPTH)))
		else $error("full status with free slots");

	// A successful pop removes exactly one entry.
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !empty && (operation == OP_POP_FRONT || operation == OP_POP_BACK))
		|=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("pop did not remove one entry");

	// A successful delete removes exactly one entry and reports ok.
	a_delete_count: assert property (@(posedge clk) disable iff (!arst_n)
		(start && operation == OP_DELETE && found[DEPTH])
		|=> (count_q == $past(count_q) - CNT_W'(1) && status == ST_OK))
		else $error("delete did not remove one entry");

endmodule

`default_nettype wire

FILE: design/dqdv_cell.sv
// ----------------------------------------------------------------------------
// dqdv_cell: one slot of the queue row
// Holds one entry, compares it with the broadcast word and moves data to or
// from its neighbours as the row command asks.
// ----------------------------------------------------------------------------
`default_nettype none

module dqdv_cell (
	input  wire logic               clk,
	input  wire dqdv_pkg::cell_cmd_t cmd,
	input  wire logic               occupied,
	input  wire logic               at_tail,
	input  wire dqdv_pkg::word_t    left_data,
	input  wire dqdv_pkg::word_t    right_data,
	input  wire logic               found_in,
	output logic                    found_out,
	output dqdv_pkg::word_t         data
);
	import dqdv_pkg::*;

	word_t data_q;
	word_t data_d;
	logic  match;

	// A held entry equal to the word extends the found chain towards the back.
	assign match     = occupied && (data_q == cmd.word);
	assign found_out = found_in || match;

	// Next entry value chosen by the row command.
	always_comb begin
		data_d = data_q;
		case (cmd.code)
			CMD_LOAD_TAIL: begin
				if (at_tail) data_d = cmd.word;
			end
			CMD_SHIFT_BACK: begin
				if (occupied || at_tail) data_d = left_data;
			end
			CMD_SHIFT_FRONT: begin
				if (occupied) data_d = right_data;
			end
			CMD_DELETE: begin
				if (occupied && found_out) data_d = right_data;
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	// Entry storage needs no reset: only occupied slots are ever observed.
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

`default_nettype wire
